// ===== hw/rtl/thick_line_stroke_expander_assert.svh =====
// Assertion macros for the stroke expander checker.
`ifndef THICK_LINE_STROKE_EXPANDER_ASSERT_SVH
`define THICK_LINE_STROKE_EXPANDER_ASSERT_SVH

// Implication checked on every edge outside reset.
`define TLSE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m failed");

// Implication checked in the cycle after the antecedent.
`define TLSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m failed");

`endif

// ===== hw/rtl/tlse_pkg.sv =====
// ----------------------------------------------------------------------------
// tlse_pkg
// Shared types and constants of the thick line stroke expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlse_pkg;

  localparam logic [1:0] PEN_DOWN = 2'd2;
  localparam logic [1:0] PEN_UP   = 2'd3;

  localparam int unsigned NUM_STROKES = 12;
  localparam int unsigned SQRT_BITS  = 33;
  localparam int unsigned DIV_BITS   = 64;

  // Point selection codes for outline strokes.
  typedef enum logic [2:0] {
    SEL_PREV,
    SEL_CUR,
    SEL_CUR_PP,
    SEL_PREV_PP,
    SEL_PREV_MP,
    SEL_CUR_MP
  } point_sel_t;

  typedef struct packed {
    logic load;       // capture input item, load pass-through result
    logic diff;       // dx, dy and their magnitudes
    logic sq_x;       // square |dx|
    logic sq_y;       // square |dy|, form sum
    logic sqrt_init;
    logic sqrt_step;
    logic div_init_x; // start off*|dx| / mag
    logic div_init_y;
    logic div_step;
    logic div_done_x; // store signed quotient
    logic div_done_y;
    logic stroke;     // load an outline stroke into the output register
    point_sel_t sel;
    logic [1:0] pen;
    logic       last;
    logic       commit; // prev <= cur
  } dp_cmd_t;

  typedef struct packed {
    logic thicken;   // pen down, offset nonzero, nonzero segment
    logic pass_only; // incoming item gives only its pass-through result
  } dp_stat_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'h7fffffff;
    if (v < -34'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

endpackage

// ===== hw/rtl/tlse_datapath.sv =====
// ----------------------------------------------------------------------------
// tlse_datapath
// Coordinate registers, bit-serial square root and divider, stroke output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlse_datapath
  import tlse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_data,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  logic [1:0]         pen_code,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [1:0]         out_pen,
  output logic               last_of_run
);

  logic [30:0]        line_offset;
  logic signed [31:0] prev_x, prev_y, cur_x, cur_y;
  logic [1:0]         cur_pen;
  logic               dx_neg, dy_neg;
  logic [32:0]        ax, ay;
  logic [65:0]        sum_sq;
  logic [65:0]        sq_tmp;
  logic [32:0]        sq_in;
  // sqrt: restoring, one bit per step
  logic [65:0]        rem;
  logic [67:0]        rem_sh;
  logic [32:0]        root;
  // divider: restoring, one bit per step
  logic [63:0]        dividend;
  logic [33:0]        drem;
  logic [33:0]        drem_sh;
  logic signed [31:0] ox, oy;
  logic               div_neg;

  logic signed [32:0] dx_w, dy_w;
  logic [34:0]        trial;
  logic [63:0]        prod;

  assign dx_w = 33'(cur_x) - 33'(prev_x);
  assign dy_w = 33'(cur_y) - 33'(prev_y);
  assign sq_in = cmd.sq_x ? ax : ay;
  assign sq_tmp = 66'(sq_in) * 66'(sq_in);

  assign rem_sh = {rem, sum_sq[65:64]};
  assign trial  = rem_sh[34:0] - {root, 2'b01};
  assign drem_sh = {drem[32:0], dividend[63]};
  assign prod = 64'(line_offset) * 64'(cmd.div_init_x ? ax : ay);

  // pass_only looks at the incoming item so its last flag is right on load
  assign stat = '{
    thicken:   (cur_pen == PEN_DOWN) && (line_offset != '0) &&
               ((ax != '0) || (ay != '0)),
    pass_only: !((pen_code == PEN_DOWN) && (line_offset != '0) &&
                 ((x_coord != prev_x) || (y_coord != prev_y)))
  };

  logic signed [33:0] sx, sy;

  always_comb begin
    sx = 34'(cur_x);
    sy = 34'(cur_y);
    unique case (cmd.sel)
      SEL_PREV:    begin sx = 34'(prev_x);          sy = 34'(prev_y);          end
      SEL_CUR:     begin sx = 34'(cur_x);           sy = 34'(cur_y);           end
      SEL_CUR_PP:  begin sx = 34'(cur_x) + 34'(oy); sy = 34'(cur_y) - 34'(ox); end
      SEL_PREV_PP: begin sx = 34'(prev_x) + 34'(oy); sy = 34'(prev_y) - 34'(ox); end
      SEL_PREV_MP: begin sx = 34'(prev_x) - 34'(oy); sy = 34'(prev_y) + 34'(ox); end
      SEL_CUR_MP:  begin sx = 34'(cur_x) - 34'(oy); sy = 34'(cur_y) + 34'(ox); end
      default:     begin sx = 34'(cur_x);           sy = 34'(cur_y);           end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_offset <= '0;
      prev_x <= '0;
      prev_y <= '0;
    end else begin
      if (cfg_we) line_offset <= cfg_data;
      if (cmd.commit) begin
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x <= x_coord;
      cur_y <= y_coord;
      cur_pen <= pen_code;
      out_x <= x_coord;
      out_y <= y_coord;
      out_pen <= pen_code;
      last_of_run <= cmd.last;
      ax <= '0;
      ay <= '0;
    end
    if (cmd.diff) begin
      dx_neg <= dx_w[32];
      dy_neg <= dy_w[32];
      ax <= dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
      ay <= dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
    end
    if (cmd.sq_x) sum_sq <= sq_tmp;
    if (cmd.sq_y) sum_sq <= sum_sq + sq_tmp;
    if (cmd.sqrt_init) begin
      rem <= '0;
      root <= '0;
    end
    if (cmd.sqrt_step) begin
      sum_sq <= {sum_sq[63:0], 2'b00};
      if (!trial[34]) begin
        rem <= 66'(trial[33:0]);
        root <= {root[31:0], 1'b1};
      end else begin
        rem <= rem_sh[65:0];
        root <= {root[31:0], 1'b0};
      end
    end
    if (cmd.div_init_x || cmd.div_init_y) begin
      dividend <= prod;
      drem <= '0;
      div_neg <= cmd.div_init_x ? dx_neg : dy_neg;
    end
    if (cmd.div_step) begin
      if (drem_sh >= 34'(root)) begin
        drem <= drem_sh - 34'(root);
        dividend <= {dividend[62:0], 1'b1};
      end else begin
        drem <= drem_sh;
        dividend <= {dividend[62:0], 1'b0};
      end
    end
    // quotient never exceeds line_offset, so 32 bits suffice
    if (cmd.div_done_x) ox <= div_neg ? -$signed(dividend[31:0]) : $signed(dividend[31:0]);
    if (cmd.div_done_y) oy <= div_neg ? -$signed(dividend[31:0]) : $signed(dividend[31:0]);
    if (cmd.stroke) begin
      out_x <= sat32(sx);
      out_y <= sat32(sy);
      out_pen <= cmd.pen;
      last_of_run <= cmd.last;
    end
  end

endmodule

// ===== hw/rtl/tlse_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlse_ctrl
// Sequencer: accepts an item, runs sqrt and divides for a thick segment, emits the strokes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlse_ctrl
  import tlse_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic [1:0] pen_code,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_CHECK, S_SQX, S_SQY, S_SQRT, S_DIVX, S_DIVY,
    S_PASS, S_STROKE
  } state_t;

  state_t     state;
  logic [6:0] cnt;
  logic [3:0] idx;
  logic       busy_out;

  point_sel_t sel_tab;
  always_comb begin
    unique case (idx)
      4'd0:    sel_tab = SEL_PREV;
      4'd1:    sel_tab = SEL_CUR;
      4'd2:    sel_tab = SEL_CUR_PP;
      4'd3:    sel_tab = SEL_PREV_PP;
      4'd4:    sel_tab = SEL_PREV_MP;
      4'd5:    sel_tab = SEL_CUR_MP;
      4'd6:    sel_tab = SEL_PREV_MP;
      4'd7:    sel_tab = SEL_CUR_PP;
      4'd8:    sel_tab = SEL_PREV_PP;
      4'd9:    sel_tab = SEL_CUR;
      4'd10:   sel_tab = SEL_PREV;
      default: sel_tab = SEL_CUR;
    endcase
  end

  logic accept;
  logic out_free;
  assign in_ready  = (state == S_IDLE) && !busy_out;
  assign out_valid = busy_out;
  assign accept    = in_valid && in_ready;
  // output register empty or being emptied this cycle
  assign out_free  = !busy_out || out_ready;

  always_comb begin
    cmd = '0;
    cmd.sel = sel_tab;
    cmd.pen = (idx == 4'd0) ? PEN_UP : PEN_DOWN;
    unique case (state)
      S_IDLE: begin
        cmd.load = accept;
        cmd.last = stat.pass_only;
        cmd.commit = 1'b0;
      end
      S_DIFF:  cmd.diff = 1'b1;
      S_SQX:   cmd.sq_x = 1'b1;
      S_SQY: begin
        cmd.sq_y = 1'b1;
        cmd.sqrt_init = 1'b1;
      end
      S_SQRT: cmd.sqrt_step = 1'b1;
      S_DIVX: begin
        cmd.div_init_x = (cnt == 7'd0);
        cmd.div_step   = (cnt != 7'd0) && (cnt <= 7'(DIV_BITS));
        cmd.div_done_x = (cnt == 7'(DIV_BITS + 1));
      end
      S_DIVY: begin
        cmd.div_init_y = (cnt == 7'd0);
        cmd.div_step   = (cnt != 7'd0) && (cnt <= 7'(DIV_BITS));
        cmd.div_done_y = (cnt == 7'(DIV_BITS + 1));
      end
      S_STROKE: begin
        cmd.stroke = out_free;
        cmd.last = (idx == 4'(NUM_STROKES - 1));
        cmd.commit = out_free && (idx == 4'(NUM_STROKES - 1));
      end
      S_CHECK: cmd.commit = !stat.thicken;
      S_PASS:  cmd.commit = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      idx <= '0;
      busy_out <= 1'b0;
    end else begin
      if (out_valid && out_ready) busy_out <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            busy_out <= 1'b1;
            state <= (pen_code == PEN_DOWN) ? S_DIFF : S_PASS;
          end
        end
        S_PASS: state <= S_IDLE;
        S_DIFF: state <= S_CHECK;
        S_CHECK: state <= stat.thicken ? S_SQX : S_IDLE;
        S_SQX: state <= S_SQY;
        S_SQY: begin
          state <= S_SQRT;
          cnt <= '0;
        end
        S_SQRT: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'(SQRT_BITS - 1)) begin
            cnt <= '0;
            state <= S_DIVX;
          end
        end
        S_DIVX: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'(DIV_BITS + 1)) begin
            cnt <= '0;
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'(DIV_BITS + 1)) begin
            cnt <= '0;
            idx <= '0;
            state <= S_STROKE;
          end
        end
        S_STROKE: begin
          if (out_free) begin
            busy_out <= 1'b1;
            idx <= idx + 4'd1;
            if (idx == 4'(NUM_STROKES - 1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/thick_line_stroke_expander.sv =====
// ----------------------------------------------------------------------------
// thick_line_stroke_expander
// Passes pen moves through and outlines thick pen-down segments.
// ----------------------------------------------------------------------------
// Each item gives its pass-through stroke on the cycle after acceptance.
// A pen-down item with nonzero offset and segment then runs the 33 steps of
// the bit-serial square root and two serial divides before the first of its
// twelve outline strokes (one per cycle when the sink is ready). One item is
// in work at a time; the next is accepted once the last stroke of the
// previous one is taken.
`timescale 1ns / 1ps

module thick_line_stroke_expander
  import tlse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  logic [1:0]         pen_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [1:0]         out_pen,
  output logic               last_of_run
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tlse_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .pen_code, .stat, .cmd
  );

  tlse_datapath u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .x_coord, .y_coord, .pen_code,
    .cmd, .stat, .out_x, .out_y, .out_pen, .last_of_run
  );

endmodule

// ===== hw/rtl/tlse_checker.sv =====
// ----------------------------------------------------------------------------
// tlse_checker
// Port-level checks of the stroke expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "thick_line_stroke_expander_assert.svh"

module tlse_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_pen,
  input logic        last_of_run
);
  // a new item is never taken while a result waits
  `TLSE_ASSERT_IMPL(a_no_accept_busy, out_valid, !in_ready)
  // accepting an item always shows its pass-through next
  `TLSE_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid)
  // stalled result holds its pen code
  `TLSE_ASSERT_NEXT(a_pen_hold, out_valid && !out_ready, $stable(out_pen))
  // stalled result stays offered with its last flag
  `TLSE_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready,
                    out_valid && $stable(last_of_run))
endmodule

bind thick_line_stroke_expander tlse_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_pen, .last_of_run
);

// ===== tb/tlse_stroke_checker.sv =====
// ----------------------------------------------------------------------------
// tlse_stroke_checker
// Watches the move and stroke channels of the stroke expander, computes the
// strokes each accepted move must produce and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlse_stroke_checker
  import tlse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  logic [1:0]         pen_code,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic [1:0]         out_pen,
  input  logic               last_of_run,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [1:0]         pen;
    logic               last;
  } stroke_t;

  stroke_t            stroke_q[$];
  logic [30:0]        half_width;
  logic signed [31:0] last_x, last_y;

  assign pending = stroke_q.size();

  function automatic logic [31:0] clamp(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // floor sqrt of a value below 2^68, bit by bit
  function automatic logic [33:0] root_floor(input logic [67:0] s);
    logic [33:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if ({34'd0, c} * {34'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] scaled(input logic [30:0] w,
                                                input logic signed [63:0] d,
                                                input logic [33:0] m);
    logic [63:0] a;
    logic [95:0] q;
    a = (d < 0) ? -d : d;
    q = ({65'd0, w} * {32'd0, a}) / {62'd0, m};
    return (d < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  task automatic push_stroke(input logic signed [63:0] x, input logic signed [63:0] y,
                             input logic [1:0] pen);
    stroke_t s;
    s.x = clamp(x);
    s.y = clamp(y);
    s.pen = pen;
    s.last = 1'b0;
    stroke_q.push_back(s);
  endtask

  task automatic predict_strokes(input logic signed [31:0] x, input logic signed [31:0] y,
                                 input logic [1:0] pen);
    logic signed [63:0] dx, dy, ox, oy, cx, cy, px, py;
    logic [67:0]        sum;
    logic [33:0]        mag;
    stroke_t            t;
    cx = x;
    cy = y;
    px = last_x;
    py = last_y;
    push_stroke(cx, cy, pen);
    dx = cx - px;
    dy = cy - py;
    if (half_width != 0 && pen == PEN_DOWN && (dx != 0 || dy != 0)) begin
      // squares stay below 2^64, so read them as unsigned
      sum = 68'($unsigned(dx * dx)) + 68'($unsigned(dy * dy));
      mag = root_floor(sum);
      ox = scaled(half_width, dx, mag);
      oy = scaled(half_width, dy, mag);
      push_stroke(px, py, PEN_UP);
      push_stroke(cx, cy, PEN_DOWN);
      push_stroke(cx + oy, cy - ox, PEN_DOWN);
      push_stroke(px + oy, py - ox, PEN_DOWN);
      push_stroke(px - oy, py + ox, PEN_DOWN);
      push_stroke(cx - oy, cy + ox, PEN_DOWN);
      push_stroke(px - oy, py + ox, PEN_DOWN);
      push_stroke(cx + oy, cy - ox, PEN_DOWN);
      push_stroke(px + oy, py - ox, PEN_DOWN);
      push_stroke(cx, cy, PEN_DOWN);
      push_stroke(px, py, PEN_DOWN);
      push_stroke(cx, cy, PEN_DOWN);
    end
    t = stroke_q.pop_back();
    t.last = 1'b1;
    stroke_q.push_back(t);
    last_x = x;
    last_y = y;
  endtask

  always @(posedge clk) begin
    stroke_t e;
    if (rst) begin
      half_width <= '0;
      last_x = '0;
      last_y = '0;
      stroke_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) half_width <= cfg_data;
      if (in_valid && in_ready) predict_strokes(x_coord, y_coord, pen_code);
      if (out_valid && out_ready) begin
        if (stroke_q.size() == 0) begin
          $error("unexpected stroke x=%0d y=%0d pen=%0d", out_x, out_y, out_pen);
          fail_count <= fail_count + 1;
        end else begin
          e = stroke_q.pop_front();
          if (out_x !== e.x || out_y !== e.y || out_pen !== e.pen
              || last_of_run !== e.last) begin
            if (out_x !== e.x) $error("out_x exp %0d got %0d", e.x, out_x);
            if (out_y !== e.y) $error("out_y exp %0d got %0d", e.y, out_y);
            if (out_pen !== e.pen) $error("out_pen exp %0d got %0d", e.pen, out_pen);
            if (last_of_run !== e.last)
              $error("last_of_run exp %0d got %0d", e.last, last_of_run);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_thick_line_stroke_expander.sv =====
// ----------------------------------------------------------------------------
// tb_thick_line_stroke_expander
// Drives pen moves with random bursts and sink stalls across several line
// widths; the checker predicts and compares every stroke.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_thick_line_stroke_expander;
  import tlse_pkg::*;

  localparam int TAIL_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1500000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [30:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] x_coord = '0, y_coord = '0;
  logic [1:0]         pen_code = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_x, out_y;
  logic [1:0]         out_pen;
  logic               last_of_run;
  int                 fail_count, pending;
  int                 cycle_count = 0;
  int                 hold_off = 0;   // long sink stall, cycles left
  logic signed [31:0] pen_x = '0, pen_y = '0;

  always #2 clk = ~clk;

  thick_line_stroke_expander dut (.*);

  tlse_stroke_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // sink: a long hold-off when requested, else a pattern of stall stretches
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (cycle_count % 512 < 128) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_move(input logic signed [31:0] x, input logic signed [31:0] y,
                           input logic [1:0] pen);
    in_valid <= 1'b1;
    x_coord <= x;
    y_coord <= y;
    pen_code <= pen;
    do @(posedge clk); while (!in_ready);
    pen_x = x;
    pen_y = y;
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(input logic [30:0] w);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] near(input logic signed [31:0] c);
    logic signed [63:0] v;
    v = 64'(c) + $signed(64'($urandom_range(0, 2000000))) - 64'sd1000000;
    return 32'(v);
  endfunction

  task automatic random_moves(input int count);
    int burst;
    logic [1:0] pen;
    burst = $urandom_range(1, 10);
    for (int i = 0; i < count; i++) begin
      pen = ($urandom_range(0, 4) != 0) ? PEN_DOWN : 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: send_move($urandom, $urandom, pen);
        1: send_move(pen_x, pen_y, pen);
        2: send_move(($urandom & 1) ? 32'sh7fffffff : 32'sh80000000,
                     ($urandom & 1) ? 32'sh7fffffff : 32'sh80000000, pen);
        default: send_move(near(pen_x), near(pen_y), pen);
      endcase
      if (--burst == 0) begin
        pause_sender();
        burst = $urandom_range(1, 10);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // zero width: everything passes through
    send_move(32'sh00010000, 32'sh00020000, PEN_DOWN);
    send_move(32'sh7fffffff, 32'sh80000000, PEN_UP);
    send_move(-32'sd1, 32'sd5, 2'd0);
    send_move(32'sd0, 32'sd0, 2'd1);
    set_width(31'h00010000);
    send_move(32'sh00050000, 32'sh00050000, PEN_DOWN);
    send_move(32'sh00050000, 32'sh00050000, PEN_DOWN);  // zero segment
    send_move(32'sh00080000, 32'sh00010000, PEN_UP);
    send_move(32'sh00080000, -32'sh00030000, PEN_DOWN);
    send_move(32'sh80000000, 32'sh80000000, PEN_DOWN);
    send_move(32'sh7fffffff, 32'sh7fffffff, PEN_DOWN);
    send_move(32'sh7fffffff, 32'sh80000000, PEN_DOWN);
    send_move(32'sh80000000, 32'sh7fffffff, PEN_DOWN);
    send_move(32'sh80000001, 32'sh7fffffff, 2'd0);
    set_width(31'h7fffffff);
    send_move(32'sh7ffffff0, 32'sh7ffffff0, PEN_DOWN);
    send_move(32'sh80000000, 32'sh80000000, PEN_DOWN);
    send_move(32'sh80000000, 32'sh80000001, PEN_DOWN);
    send_move(32'sd3, 32'sd4, PEN_DOWN);
    // long sink stall while moves keep coming
    hold_off = 600;
    random_moves(10);
    set_width(31'd1);
    random_moves(60);
    set_width(31'h00028000);
    random_moves(80);
    drain();
    set_width(31'h7fffffff);
    random_moves(50);
    set_width(31'($urandom));
    random_moves(40);
    drain();
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
